// ===== src/srw_pkg.sv =====
package srw_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] len;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t ent;
    } cmd_t;

    // head-run summary travelling down the chain
    typedef struct packed {
        logic        inrun;
        logic [4:0]  cnt;
        logic [19:0] acc;
        logic [31:0] hi;
    } wave_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

endpackage

// ===== src/srw_cell.sv =====
module srw_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head,
    input  srw_pkg::cmd_t  cmd,
    input  logic           prev_valid,
    input  srw_pkg::entry_t prev_ent,
    input  logic           prev_lt,
    input  logic           next_valid,
    input  srw_pkg::entry_t next_ent,
    input  srw_pkg::wave_t wave_in,
    output logic           valid,
    output srw_pkg::entry_t ent,
    output logic           lt,
    output logic           eq,
    output srw_pkg::wave_t wave_out
);

    logic            valid_reg, valid_next;
    srw_pkg::entry_t ent_reg, ent_next;
    srw_pkg::wave_t  wave_reg, wave_next;
    logic            link;
    logic            run;

    assign lt = valid_reg && (cmd.ent.id > ent_reg.id);
    assign eq = valid_reg && (cmd.ent.id == ent_reg.id);

    always_comb begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (cmd.insert) begin
            if (!lt) begin
                if (head || prev_lt) begin
                    valid_next = 1'b1;
                    ent_next   = cmd.ent;
                end else begin
                    valid_next = prev_valid;
                    ent_next   = prev_ent;
                end
            end
        end else if (cmd.pop) begin
            valid_next = next_valid;
            ent_next   = next_ent;
        end
    end

    assign link = valid_reg && (head || ((prev_ent.id + 32'd1) == ent_reg.id));
    assign run  = wave_in.inrun && link;

    always_comb begin
        wave_next.inrun = run;
        wave_next.cnt   = wave_in.cnt + {4'd0, run};
        wave_next.acc   = wave_in.acc + (run ? {4'd0, ent_reg.len} : 20'd0);
        wave_next.hi    = valid_reg ? ent_reg.id : wave_in.hi;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg  <= ent_next;
        wave_reg <= wave_next;
    end

    assign valid    = valid_reg;
    assign ent      = ent_reg;
    assign wave_out = wave_reg;

endmodule

// ===== src/sorted_reorder_window.sv =====
// Sorted reorder window: holds up to DEPTH fragments ordered by ascending ID.
// Input channel (s_*): one request per item; s_operation selects insert or
// pop. Insert places the fragment in ID order unless the ID is already held
// (duplicate) or the window is full. Pop removes the lowest-ID fragment.
// Output channel (m_*): exactly one result per request with status, popped
// fragment, occupancy, first/highest ID and the contiguous head run.
// Storage is a row of cells; each cell compares the request ID with its own
// entry and either keeps it, takes the new fragment or its neighbor's.
// The head-run count, byte sum and highest ID ripple down the row one cell
// per cycle; the next request is taken the cycle after the result has been
// moved to the output register.
// A result waiting on m_ready does not block the next request; the block
// holds s_ready low only while a result is still in the row.
// Reset (aresetn low, synchronous) empties the window and drops any result.
module sorted_reorder_window (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_entry_id,
    input  logic [15:0] s_entry_length,
    input  logic [15:0] s_entry_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_popped_id,
    output logic [15:0] m_popped_length,
    output logic [15:0] m_popped_tag,
    output logic        m_window_valid,
    output logic [31:0] m_first_id,
    output logic [31:0] m_highest_id,
    output logic [4:0]  m_run_count,
    output logic [19:0] m_run_bytes,
    output logic [4:0]  m_occupancy
);

    localparam int D = srw_pkg::DEPTH;

    logic [D-1:0]    valid_a;
    logic [D-1:0]    lt_a;
    logic [D-1:0]    eq_a;
    srw_pkg::entry_t ent_a   [D];
    srw_pkg::wave_t  wave_a  [D];

    srw_pkg::cmd_t   cmd;
    srw_pkg::state_t state_reg, state_next;
    logic [srw_pkg::IDX_W-1:0] scan_reg, scan_next;

    logic        accept;
    logic        is_pop;
    logic        dup;
    logic        full;
    logic        empty;
    logic [1:0]  status;
    logic        load;

    logic [1:0]  status_reg;
    srw_pkg::entry_t popped_reg;
    logic [4:0]  occ_reg, occ_next;

    logic        m_valid_reg;
    logic [1:0]  o_status_reg;
    srw_pkg::entry_t o_popped_reg;
    logic        o_wvalid_reg;
    logic [31:0] o_first_reg;
    logic [31:0] o_high_reg;
    logic [4:0]  o_cnt_reg;
    logic [19:0] o_bytes_reg;
    logic [4:0]  o_occ_reg;

    assign s_ready = (state_reg == srw_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_pop  = (s_operation == srw_pkg::OP_POP);
    assign dup     = |eq_a;
    assign full    = valid_a[D-1];
    assign empty   = !valid_a[0];

    always_comb begin
        cmd.ent.id  = s_entry_id;
        cmd.ent.len = s_entry_length;
        cmd.ent.tag = s_entry_tag;
        cmd.insert  = accept && !is_pop && !dup && !full;
        cmd.pop     = accept && is_pop && !empty;
    end

    always_comb begin
        if (is_pop) begin
            status = empty ? srw_pkg::STAT_EMPTY : srw_pkg::STAT_OK;
        end else if (dup) begin
            status = srw_pkg::STAT_DUP;
        end else if (full) begin
            status = srw_pkg::STAT_FULL;
        end else begin
            status = srw_pkg::STAT_OK;
        end
    end

    genvar i;
    generate
        for (i = 0; i < D; i++) begin : g_cell
            logic            p_valid, p_lt, n_valid;
            srw_pkg::entry_t p_ent, n_ent;
            srw_pkg::wave_t  w_in;

            if (i == 0) begin : g_head
                assign p_valid  = 1'b0;
                assign p_lt     = 1'b0;
                assign p_ent    = '0;
                assign w_in.inrun = 1'b1;
                assign w_in.cnt   = 5'd0;
                assign w_in.acc   = 20'd0;
                assign w_in.hi    = 32'd0;
            end else begin : g_body
                assign p_valid = valid_a[i-1];
                assign p_lt    = lt_a[i-1];
                assign p_ent   = ent_a[i-1];
                assign w_in    = wave_a[i-1];
            end

            if (i == D - 1) begin : g_tail
                assign n_valid = 1'b0;
                assign n_ent   = '0;
            end else begin : g_link
                assign n_valid = valid_a[i+1];
                assign n_ent   = ent_a[i+1];
            end

            srw_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .head       (i == 0),
                .cmd        (cmd),
                .prev_valid (p_valid),
                .prev_ent   (p_ent),
                .prev_lt    (p_lt),
                .next_valid (n_valid),
                .next_ent   (n_ent),
                .wave_in    (w_in),
                .valid      (valid_a[i]),
                .ent        (ent_a[i]),
                .lt         (lt_a[i]),
                .eq         (eq_a[i]),
                .wave_out   (wave_a[i])
            );
        end
    endgenerate

    assign load = (state_reg == srw_pkg::ST_LOAD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        occ_next   = occ_reg;
        if (cmd.insert) begin
            occ_next = occ_reg + 5'd1;
        end else if (cmd.pop) begin
            occ_next = occ_reg - 5'd1;
        end
        case (state_reg)
            srw_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = srw_pkg::ST_SCAN;
                    scan_next  = '0;
                end
            end
            srw_pkg::ST_SCAN: begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == srw_pkg::IDX_W'(D - 1)) begin
                    state_next = srw_pkg::ST_LOAD;
                end
            end
            srw_pkg::ST_LOAD: begin
                if (load) begin
                    state_next = srw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srw_pkg::ST_IDLE;
            scan_reg    <= '0;
            occ_reg     <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            occ_reg   <= occ_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            popped_reg <= cmd.pop ? ent_a[0] : '0;
        end
        if (load) begin
            o_status_reg <= status_reg;
            o_popped_reg <= popped_reg;
            o_wvalid_reg <= valid_a[0];
            o_first_reg  <= valid_a[0] ? ent_a[0].id : 32'd0;
            o_high_reg   <= valid_a[0] ? wave_a[D-1].hi : 32'd0;
            o_cnt_reg    <= valid_a[0] ? wave_a[D-1].cnt : 5'd0;
            o_bytes_reg  <= valid_a[0] ? wave_a[D-1].acc : 20'd0;
            o_occ_reg    <= occ_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = o_status_reg;
    assign m_popped_id     = o_popped_reg.id;
    assign m_popped_length = o_popped_reg.len;
    assign m_popped_tag    = o_popped_reg.tag;
    assign m_window_valid  = o_wvalid_reg;
    assign m_first_id      = o_first_reg;
    assign m_highest_id    = o_high_reg;
    assign m_run_count     = o_cnt_reg;
    assign m_run_bytes     = o_bytes_reg;
    assign m_occupancy     = o_occ_reg;

endmodule

// ===== src/srw_checker.sv =====
module srw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_popped_id,
    input logic        m_window_valid,
    input logic [31:0] m_first_id,
    input logic [4:0]  m_occupancy
);

    // one request in the row at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in the row");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_first_id)))
        else $error("stalled result changed");

    a_empty_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_window_valid) |-> (m_first_id == 32'd0 && m_occupancy == 5'd0))
        else $error("empty window reports content");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == srw_pkg::STAT_EMPTY) |-> (!m_window_valid && m_popped_id == 32'd0))
        else $error("pop on empty reports a fragment");

    a_reject_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == srw_pkg::STAT_DUP || m_status == srw_pkg::STAT_FULL))
            |-> (m_window_valid && m_popped_id == 32'd0))
        else $error("rejected insert reports a popped fragment");

endmodule

bind sorted_reorder_window srw_checker u_srw_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_popped_id    (m_popped_id),
    .m_window_valid (m_window_valid),
    .m_first_id     (m_first_id),
    .m_occupancy    (m_occupancy)
);

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] popped_id;
        logic [15:0] popped_length;
        logic [15:0] popped_tag;
        logic        window_valid;
        logic [31:0] first_id;
        logic [31:0] highest_id;
        logic [4:0]  run_count;
        logic [19:0] run_bytes;
        logic [4:0]  occupancy;
    } window_view_t;

    class window_tracker;
        logic [31:0]  ids [srw_pkg::DEPTH];
        logic [15:0]  lens [srw_pkg::DEPTH];
        logic [15:0]  tags [srw_pkg::DEPTH];
        int           held;
        int           noted;
        int           errors;
        window_view_t expected_views [$];

        function new();
            held = 0;
            noted = 0;
            errors = 0;
        endfunction

        // applies one accepted request to the window and queues the view it yields
        function void note_request(logic op, logic [31:0] id, logic [15:0] len,
                                   logic [15:0] tag);
            window_view_t v;
            bit           dup;
            bit           in_run;
            int           pos;
            logic [31:0]  nxt;
            v = '{default: '0};
            noted++;
            if (op == srw_pkg::OP_INSERT) begin
                dup = 0;
                for (int i = 0; i < held; i++)
                    if (ids[i] == id) dup = 1;
                if (dup) begin
                    v.status = srw_pkg::STAT_DUP;
                end else if (held >= srw_pkg::DEPTH) begin
                    v.status = srw_pkg::STAT_FULL;
                end else begin
                    pos = 0;
                    for (int i = 0; i < held; i++)
                        if (id > ids[i]) pos++;
                    for (int i = held; i > pos; i--) begin
                        ids[i]  = ids[i-1];
                        lens[i] = lens[i-1];
                        tags[i] = tags[i-1];
                    end
                    ids[pos]  = id;
                    lens[pos] = len;
                    tags[pos] = tag;
                    held++;
                    v.status = srw_pkg::STAT_OK;
                end
            end else begin
                if (held == 0) begin
                    v.status = srw_pkg::STAT_EMPTY;
                end else begin
                    v.status        = srw_pkg::STAT_OK;
                    v.popped_id     = ids[0];
                    v.popped_length = lens[0];
                    v.popped_tag    = tags[0];
                    for (int i = 1; i < held; i++) begin
                        ids[i-1]  = ids[i];
                        lens[i-1] = lens[i];
                        tags[i-1] = tags[i];
                    end
                    held--;
                end
            end
            v.window_valid = (held > 0);
            if (held > 0) begin
                v.first_id   = ids[0];
                v.highest_id = ids[held-1];
                v.run_count  = 5'd1;
                v.run_bytes  = 20'(lens[0]);
                in_run = 1;
                for (int i = 1; i < held; i++) begin
                    nxt = ids[i-1] + 32'd1;
                    if (nxt != ids[i]) in_run = 0;
                    if (in_run) begin
                        v.run_count = v.run_count + 5'd1;
                        v.run_bytes = v.run_bytes + 20'(lens[i]);
                    end
                end
            end
            v.occupancy = 5'(held);
            expected_views.push_back(v);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        endtask

        task check_field(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_result(window_view_t got);
            window_view_t want;
            if (expected_views.size() == 0) begin
                report_mismatch("result with no request pending", 64'(got.status), 64'd0);
                return;
            end
            want = expected_views.pop_front();
            check_field("status", 64'(got.status), 64'(want.status));
            check_field("popped_id", 64'(got.popped_id), 64'(want.popped_id));
            check_field("popped_length", 64'(got.popped_length), 64'(want.popped_length));
            check_field("popped_tag", 64'(got.popped_tag), 64'(want.popped_tag));
            check_field("window_valid", 64'(got.window_valid), 64'(want.window_valid));
            check_field("first_id", 64'(got.first_id), 64'(want.first_id));
            check_field("highest_id", 64'(got.highest_id), 64'(want.highest_id));
            check_field("run_count", 64'(got.run_count), 64'(want.run_count));
            check_field("run_bytes", 64'(got.run_bytes), 64'(want.run_bytes));
            check_field("occupancy", 64'(got.occupancy), 64'(want.occupancy));
        endtask
    endclass

    localparam int RANDOM_REQUESTS = 830;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_AFTER      = 330;
    localparam int HOLD_CYCLES     = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [31:0] s_entry_id = '0;
    logic [15:0] s_entry_length = '0;
    logic [15:0] s_entry_tag = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_popped_id;
    logic [15:0] m_popped_length;
    logic [15:0] m_popped_tag;
    logic        m_window_valid;
    logic [31:0] m_first_id;
    logic [31:0] m_highest_id;
    logic [4:0]  m_run_count;
    logic [19:0] m_run_bytes;
    logic [4:0]  m_occupancy;

    window_tracker tracker;
    bit            calm = 0;
    int            idle_cycles = 0;

    sorted_reorder_window u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_entry_id      (s_entry_id),
        .s_entry_length  (s_entry_length),
        .s_entry_tag     (s_entry_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_popped_id     (m_popped_id),
        .m_popped_length (m_popped_length),
        .m_popped_tag    (m_popped_tag),
        .m_window_valid  (m_window_valid),
        .m_first_id      (m_first_id),
        .m_highest_id    (m_highest_id),
        .m_run_count     (m_run_count),
        .m_run_bytes     (m_run_bytes),
        .m_occupancy     (m_occupancy)
    );

    always #1 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_request(logic op, logic [31:0] id, logic [15:0] len,
                                logic [15:0] tag);
        int gap;
        bit accepted;
        gap = gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_entry_id     <= id;
        s_entry_length <= len;
        s_entry_tag    <= tag;
        accepted = 0;
        while (!accepted) begin
            @(posedge aclk);
            accepted = s_ready;
        end
        tracker.note_request(op, id, len, tag);
    endtask

    task automatic run_directed();
        send_request(srw_pkg::OP_POP, 32'h0, 16'h0, 16'h0);
        send_request(srw_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_request(srw_pkg::OP_INSERT, 32'h0, 16'h0, 16'h0);
        send_request(srw_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h1234, 16'h5678);
        send_request(srw_pkg::OP_INSERT, 32'hFFFF_FFFE, 16'h00A5, 16'h5A00);
        repeat (3) send_request(srw_pkg::OP_POP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_request(srw_pkg::OP_POP, 32'h0, 16'h0, 16'h0);
        // scrambled fill of one consecutive block, all lengths at maximum
        for (int i = 0; i < srw_pkg::DEPTH; i++)
            send_request(srw_pkg::OP_INSERT, 32'd1000 + 32'((i * 7) % srw_pkg::DEPTH),
                         16'hFFFF, 16'(i));
        send_request(srw_pkg::OP_INSERT, 32'd5000, 16'h0001, 16'h0001);
        send_request(srw_pkg::OP_INSERT, 32'd1003, 16'h0002, 16'h0002);
    endtask

    task automatic run_random();
        int          sent;
        int          seg_len;
        int          pop_pct;
        int          r;
        logic [31:0] base;
        logic [31:0] anchor;
        logic [31:0] id;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            seg_len = $urandom_range(40, 120);
            case ($urandom_range(0, 3))
                0:       pop_pct = 15;
                1:       pop_pct = 35;
                2:       pop_pct = 50;
                default: pop_pct = 80;
            endcase
            case ($urandom_range(0, 4))
                0:       base = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
                1:       base = 32'h0;
                default: base = $urandom;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_REQUESTS; k++) begin
                r = $urandom_range(0, 99);
                if (r < pop_pct) begin
                    send_request(srw_pkg::OP_POP, $urandom, 16'($urandom), 16'($urandom));
                end else begin
                    anchor = (tracker.held > 0) ? tracker.ids[0] : base;
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        id = anchor + 32'($urandom_range(0, 24));
                    else if (r < 90 && tracker.held > 0)
                        id = tracker.ids[$urandom_range(0, tracker.held - 1)];
                    else
                        id = $urandom;
                    send_request(srw_pkg::OP_INSERT, id, pick_length(), 16'($urandom));
                end
                sent++;
            end
        end
        calm = 0;
    endtask

    initial begin
        int ready_left;
        int stall_left;
        int hold_left;
        bit held_off;
        ready_left = 0;
        stall_left = 0;
        hold_left = 0;
        held_off = 0;
        forever begin
            @(negedge aclk);
            if (!held_off && tracker.noted >= HOLD_AFTER) begin
                held_off = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (ready_left > 0) begin
                m_ready <= 1'b1;
                ready_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                ready_left = $urandom_range(0, 20);
                stall_left = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        window_view_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status        = m_status;
            got.popped_id     = m_popped_id;
            got.popped_length = m_popped_length;
            got.popped_tag    = m_popped_tag;
            got.window_valid  = m_window_valid;
            got.first_id      = m_first_id;
            got.highest_id    = m_highest_id;
            got.run_count     = m_run_count;
            got.run_bytes     = m_run_bytes;
            got.occupancy     = m_occupancy;
            tracker.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        tracker = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.expected_views.size() > 0) @(posedge aclk);
        repeat (3 * (srw_pkg::DEPTH + 2)) @(posedge aclk);
        if (tracker.expected_views.size() > 0)
            tracker.report_mismatch("requests left without result",
                                    64'(tracker.expected_views.size()), 64'd0);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
